[src/sdlp_pkg.sv]
`default_nettype none

package sdlp_pkg;

    localparam int CH_W    = 8;
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // year, month, day packed from bit 0, padded to whole bytes
    localparam int DATA_BITS = YEAR_W + MONTH_W + DAY_W;
    localparam int M_DATA_W  = ((DATA_BITS + 7) / 8) * 8;

    localparam logic [CH_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [CH_W-1:0] CHAR_DASH  = 8'h2D;
    localparam logic [CH_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic               emit;
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               list_failed;
        logic               list_end;
    } sdlp_result_t;

endpackage

`default_nettype wire

[src/sdlp_core.sv]
`default_nettype none

module sdlp_core (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic [sdlp_pkg::CH_W-1:0]  ch,
    input  wire logic                       last,
    output sdlp_pkg::sdlp_result_t          res
);
    import sdlp_pkg::*;

    localparam int SHORT_W = 7;
    localparam logic [14:0] RECIP_25 = 15'd20972; // ceil(2^19 / 25)

    typedef struct packed {
        logic [1:0]         pi;
        logic [2:0]         dc;
        logic [YEAR_W-1:0]  acc;
        logic [YEAR_W-1:0]  fp;
        logic [SHORT_W-1:0] sp;
        logic               f4;
        logic               err;
    } parse_t;

    function automatic parse_t close_part(parse_t p, logic more);
        parse_t q;
        q = p;
        if (p.pi == 2'd0)
        begin
            if (p.dc == 3'd4)
                q.f4 = 1'b1;
            else if (p.dc == 3'd2)
                q.f4 = 1'b0;
            else
                q.err = 1'b1;
            q.fp = p.acc;
        end
        else if (p.pi == 2'd1)
        begin
            if (p.dc != 3'd2 || (more && !p.f4))
                q.err = 1'b1;
            q.sp = p.acc[SHORT_W-1:0];
        end
        else
        begin
            if (p.dc != 3'd2 || more)
                q.err = 1'b1;
        end
        if (more && p.pi < 2'd2)
            q.pi = p.pi + 2'd1;
        q.dc = 3'd0;
        if (more)
            q.acc = '0;
        return q;
    endfunction

    // y divisible by 25, by reciprocal; exact for all 14-bit years
    function automatic logic is_leap(logic [YEAR_W-1:0] y);
        logic [28:0]       prod;
        logic [9:0]        q;
        logic [YEAR_W-1:0] back;
        logic              div25;
        prod  = {15'b0, y} * {14'b0, RECIP_25};
        q     = prod[28:19];
        back  = ({4'b0, q} << 4) + ({4'b0, q} << 3) + {4'b0, q};
        div25 = (back == y);
        return (y[1:0] == 2'b00) && (!div25 || y[3:0] == 4'd0);
    endfunction

    function automatic logic calendar_ok(logic [YEAR_W-1:0] y, logic [SHORT_W-1:0] m,
                                         logic [SHORT_W-1:0] d);
        logic ok;
        if (y > 14'd9999 || m > 7'd12)
            ok = 1'b0;
        else if (m == 7'd0)
            ok = (y == '0) ? (d >= 7'd1 && d <= 7'd31) : (d == 7'd0);
        else if (d == 7'd0)
            ok = 1'b1;
        else
        begin
            case (m)
                7'd4, 7'd6, 7'd9, 7'd11: ok = (d <= 7'd30);
                7'd2:                    ok = (d == 7'd29) ? is_leap(y) : (d <= 7'd28);
                default:                 ok = (d <= 7'd31);
            endcase
        end
        return ok;
    endfunction

    parse_t             cur_reg, cur_next;
    logic               pp_reg, pp_next;
    logic               phy_reg, phy_next;
    logic               phm_reg, phm_next;
    logic               phd_reg, phd_next;
    logic [YEAR_W-1:0]  py_reg, py_next;
    logic [MONTH_W-1:0] pm_reg, pm_next;

    always_comb
    begin
        parse_t             p;
        logic               is_digit;
        logic               ends;
        logic               ok;
        logic               hy, hm, hd;
        logic [YEAR_W-1:0]  y;
        logic [SHORT_W-1:0] m, d;
        logic [1:0]         np;

        p        = cur_reg;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        ends     = last;
        ok       = 1'b1;
        hy = 1'b0; hm = 1'b0; hd = 1'b0;
        y  = '0;   m  = '0;   d  = '0;
        np = 2'd0;

        pp_next  = pp_reg;
        phy_next = phy_reg;
        phm_next = phm_reg;
        phd_next = phd_reg;
        py_next  = py_reg;
        pm_next  = pm_reg;

        res = '0;

        if (is_digit)
        begin
            if (p.dc < 3'd4)
                p.acc = {p.acc[10:0], 3'b000} + {p.acc[12:0], 1'b0} + {10'b0, ch[3:0]};
            if (p.dc < 3'd7)
                p.dc = p.dc + 3'd1;
        end
        else if (ch == CHAR_DASH)
        begin
            p = close_part(p, 1'b1);
            if (last)
                p.err = 1'b1;
        end
        else if (ch == CHAR_COMMA)
            ends = 1'b1;
        else
            p.err = 1'b1;

        if (ends)
        begin
            p  = close_part(p, 1'b0);
            np = p.pi;  // part count minus one
            if (p.f4)
            begin
                y  = p.fp;
                hy = 1'b1;
                if (np >= 2'd1)
                begin
                    m  = p.sp;
                    hm = 1'b1;
                end
                if (np == 2'd2)
                begin
                    d  = p.acc[SHORT_W-1:0];
                    hd = 1'b1;
                end
            end
            else if (!pp_reg)
                ok = 1'b0;
            else if (np == 2'd1)
            begin
                if (phy_reg && !phm_reg)
                    ok = 1'b0;
                y  = py_reg;
                m  = p.fp[SHORT_W-1:0];
                d  = p.sp;
                hm = 1'b1;
                hd = 1'b1;
            end
            else if (np == 2'd0)
            begin
                if (phm_reg && !phd_reg)
                begin
                    y  = py_reg;
                    m  = p.fp[SHORT_W-1:0];
                    hm = 1'b1;
                end
                else if (phd_reg && !(phy_reg && !phm_reg))
                begin
                    y  = py_reg;
                    m  = {3'b0, pm_reg};
                    d  = p.fp[SHORT_W-1:0];
                    hd = 1'b1;
                end
                else
                    ok = 1'b0;
            end
            else
                ok = 1'b0;

            if (ok && !pp_reg && y == '0)
                ok = 1'b0;
            if (ok && !calendar_ok(y, m, d))
                ok = 1'b0;
            if (!ok)
                p.err = 1'b1;

            res.emit = 1'b1;
            if (ok && !p.err)
            begin
                pp_next    = 1'b1;
                phy_next   = hy;
                phm_next   = hm;
                phd_next   = hd;
                py_next    = y;
                pm_next    = m[MONTH_W-1:0];
                res.year   = y;
                res.month  = m[MONTH_W-1:0];
                res.day    = d[DAY_W-1:0];
            end

            // comma on the final character leaves an empty date behind it
            if (ch == CHAR_COMMA && last)
            begin
                p.err     = 1'b1;
                res.year  = '0;
                res.month = '0;
                res.day   = '0;
            end

            res.list_failed = p.err;
            res.list_end    = last;

            if (last)
            begin
                p        = '0;
                pp_next  = 1'b0;
                phy_next = 1'b0;
                phm_next = 1'b0;
                phd_next = 1'b0;
                py_next  = '0;
                pm_next  = '0;
            end
            else
            begin
                p.pi  = '0;
                p.dc  = '0;
                p.acc = '0;
                p.fp  = '0;
                p.sp  = '0;
                p.f4  = 1'b0;
            end
        end

        cur_next = p;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            pp_reg  <= 1'b0;
            phy_reg <= 1'b0;
            phm_reg <= 1'b0;
            phd_reg <= 1'b0;
            py_reg  <= '0;
            pm_reg  <= '0;
        end
        else if (step)
        begin
            cur_reg <= cur_next;
            pp_reg  <= pp_next;
            phy_reg <= phy_next;
            phm_reg <= phm_next;
            phd_reg <= phd_next;
            py_reg  <= py_next;
            pm_reg  <= pm_next;
        end
    end

endmodule

`default_nettype wire

[src/sgf_date_list_parser_top.sv]
// Date list parser: one character of a comma-separated date list per transfer.
//
// Slave stream : s_tdata carries the character, s_tlast marks the final
//                character of the list.
// Master stream: one transfer per comma and one for the final character.
//                m_tdata holds the resolved year, month and day, m_tuser is
//                the sticky list failure flag (fields then read zero),
//                m_tlast marks the result for the last date of the list.
//
// A character taken is held in the input register and parsed from there; its
// result is captured in the result register when the character is processed.
// One character per cycle while the output is not stalled, set by the single
// combinational parse step between the input and result registers. A character
// that ends no date gives no output transfer.
//
// Reset clears the parse state, the preceding-date record and the valid bits
// of both registers. While a result waits and m_tready is low the result
// register holds; characters that end no date still pass through, and the
// stall only reaches s_tready once the held character would produce a second result.
`default_nettype none

module sgf_date_list_parser_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sdlp_pkg::CH_W-1:0]     s_tdata,   // [7:0] ch
    input  wire logic                          s_tlast,   // last
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sdlp_pkg::M_DATA_W-1:0]      m_tdata,   // [13:0] year, [17:14] month,
                                                          // [22:18] day, rest zero
    output logic                               m_tuser,   // [0] list_failed
    output logic                               m_tlast    // list_end
);
    import sdlp_pkg::*;

    logic              in_valid_reg;
    logic [CH_W-1:0]   in_ch_reg;
    logic              in_last_reg;

    logic              out_valid_reg;
    logic [YEAR_W-1:0] out_year_reg;
    logic [MONTH_W-1:0] out_month_reg;
    logic [DAY_W-1:0]  out_day_reg;
    logic              out_failed_reg;
    logic              out_end_reg;

    sdlp_result_t      res;
    logic              out_free;
    logic              proc;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && (!res.emit || out_free);
    assign s_tready = !in_valid_reg || proc;

    sdlp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (proc),
        .ch    (in_ch_reg),
        .last  (in_last_reg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= proc && res.emit;
    end

    always_ff @(posedge clk)
    begin
        if (proc && res.emit)
        begin
            out_year_reg   <= res.year;
            out_month_reg  <= res.month;
            out_day_reg    <= res.day;
            out_failed_reg <= res.list_failed;
            out_end_reg    <= res.list_end;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - DATA_BITS){1'b0}}, out_day_reg, out_month_reg,
                       out_year_reg};
    assign m_tuser  = out_failed_reg;
    assign m_tlast  = out_end_reg;

endmodule

`default_nettype wire
